// ----- rtl/core/htsm_pkg.sv -----
// package: lexer state codes, character constants and classifier functions
`default_nettype none

package htsm_pkg;

    // lexer state codes
    typedef enum logic [3:0] {
        ST_TEXT   = 4'd0,
        ST_TAG0   = 4'd1,
        ST_TAG    = 4'd2,
        ST_EQL    = 4'd3,
        ST_SQUOTE = 4'd4,
        ST_DQUOTE = 4'd5,
        ST_VALUE  = 4'd6,
        ST_AMP    = 4'd7,
        ST_CMNT1  = 4'd8,
        ST_CMNT2  = 4'd9,
        ST_CMNT   = 4'd10,
        ST_NCMNT1 = 4'd11,
        ST_NCMNT2 = 4'd12,
        ST_NCMNT3 = 4'd13,
        ST_IRRTAG = 4'd14
    } htsm_state_t;

    // result of one lexer step
    typedef struct packed {
        htsm_state_t state;
        logic        is_text;
    } htsm_result_t;

    // characters that steer the lexer
    localparam logic [7:0] CH_LT     = 8'h3C;  // <
    localparam logic [7:0] CH_GT     = 8'h3E;  // >
    localparam logic [7:0] CH_AMP    = 8'h26;  // &
    localparam logic [7:0] CH_BANG   = 8'h21;  // !
    localparam logic [7:0] CH_EQ     = 8'h3D;  // =
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_HASH   = 8'h23;  // #
    localparam logic [7:0] CH_DASH   = 8'h2D;  // -
    localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // ascii letters and digits only
    function automatic logic is_letter_digit(input logic [7:0] c);
        is_letter_digit = ((c >= 8'h30) && (c <= 8'h39)) ||
                          ((c >= 8'h61) && (c <= 8'h7A)) ||
                          ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/htsm_if.sv -----
// interfaces: character request channel and lexer result channel
`default_nettype none

interface htsm_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface htsm_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] new_state;
    logic       is_text;

    modport source (output valid, output new_state, output is_text, input ready);
    modport sink   (input valid, input new_state, input is_text, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/htsm_step.sv -----
// one lexer step: next state and text flag for a byte in a given state
`default_nettype none

module htsm_step (
    input  var htsm_pkg::htsm_state_t  state,
    input  var logic [7:0]             in_byte,
    output htsm_pkg::htsm_result_t     result
);

    htsm_pkg::htsm_state_t next_state;
    logic                  text_flag;
    logic                  blank;
    logic                  amp_end;

    assign blank   = htsm_pkg::is_blank(in_byte);
    assign amp_end = (in_byte == htsm_pkg::CH_SEMI) ||
                     ((in_byte != htsm_pkg::CH_HASH) && (in_byte != htsm_pkg::CH_UNDER) &&
                      !htsm_pkg::is_letter_digit(in_byte));

    // next state
    always_comb
    begin
        next_state = state;
        unique case (state)
            htsm_pkg::ST_TAG0:
            begin
                if (in_byte == htsm_pkg::CH_BANG)
                    next_state = htsm_pkg::ST_CMNT1;
                else if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else if (in_byte == htsm_pkg::CH_EQ)
                    next_state = htsm_pkg::ST_EQL;
                else
                    next_state = htsm_pkg::ST_TAG;
            end
            htsm_pkg::ST_TAG:
            begin
                if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else if (in_byte == htsm_pkg::CH_EQ)
                    next_state = htsm_pkg::ST_EQL;
                else
                    next_state = htsm_pkg::ST_TAG;
            end
            htsm_pkg::ST_EQL:
            begin
                if (in_byte == htsm_pkg::CH_DQUOTE)
                    next_state = htsm_pkg::ST_DQUOTE;
                else if (in_byte == htsm_pkg::CH_SQUOTE)
                    next_state = htsm_pkg::ST_SQUOTE;
                else if (blank)
                    next_state = htsm_pkg::ST_EQL;
                else if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else
                    next_state = htsm_pkg::ST_VALUE;
            end
            htsm_pkg::ST_SQUOTE:
            begin
                if (in_byte == htsm_pkg::CH_SQUOTE)
                    next_state = htsm_pkg::ST_TAG;
            end
            htsm_pkg::ST_DQUOTE:
            begin
                if (in_byte == htsm_pkg::CH_DQUOTE)
                    next_state = htsm_pkg::ST_TAG;
            end
            htsm_pkg::ST_VALUE:
            begin
                if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else if (blank)
                    next_state = htsm_pkg::ST_TAG;
            end
            htsm_pkg::ST_AMP:
            begin
                if (amp_end)
                    next_state = htsm_pkg::ST_TEXT;
            end
            htsm_pkg::ST_CMNT1:
            begin
                if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_CMNT2;
                else if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else
                    next_state = htsm_pkg::ST_IRRTAG;
            end
            htsm_pkg::ST_CMNT2:
            begin
                if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_CMNT;
                else if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else
                    next_state = htsm_pkg::ST_IRRTAG;
            end
            htsm_pkg::ST_CMNT:
            begin
                if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_NCMNT1;
            end
            htsm_pkg::ST_NCMNT1:
            begin
                if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_NCMNT2;
                else
                    next_state = htsm_pkg::ST_CMNT;
            end
            htsm_pkg::ST_NCMNT2:
            begin
                if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_NCMNT2;
                else if (blank)
                    next_state = htsm_pkg::ST_NCMNT3;
                else
                    next_state = htsm_pkg::ST_CMNT;
            end
            htsm_pkg::ST_NCMNT3:
            begin
                if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
                else if (in_byte == htsm_pkg::CH_DASH)
                    next_state = htsm_pkg::ST_NCMNT1;
                else if (blank)
                    next_state = htsm_pkg::ST_NCMNT3;
                else
                    next_state = htsm_pkg::ST_CMNT;
            end
            htsm_pkg::ST_IRRTAG:
            begin
                if (in_byte == htsm_pkg::CH_GT)
                    next_state = htsm_pkg::ST_TEXT;
            end
            // text state, and the unused code behaves as text
            default:
            begin
                if (in_byte == htsm_pkg::CH_LT)
                    next_state = htsm_pkg::ST_TAG0;
                else if (in_byte == htsm_pkg::CH_AMP)
                    next_state = htsm_pkg::ST_AMP;
                else
                    next_state = htsm_pkg::ST_TEXT;
            end
        endcase
    end

    // text flag: any byte other than '<' seen in the text state
    always_comb
    begin
        unique case (state)
            htsm_pkg::ST_TAG0, htsm_pkg::ST_TAG, htsm_pkg::ST_EQL, htsm_pkg::ST_SQUOTE,
            htsm_pkg::ST_DQUOTE, htsm_pkg::ST_VALUE, htsm_pkg::ST_AMP, htsm_pkg::ST_CMNT1,
            htsm_pkg::ST_CMNT2, htsm_pkg::ST_CMNT, htsm_pkg::ST_NCMNT1, htsm_pkg::ST_NCMNT2,
            htsm_pkg::ST_NCMNT3, htsm_pkg::ST_IRRTAG:
                text_flag = 1'b0;
            default:
                text_flag = (in_byte != htsm_pkg::CH_LT);
        endcase
    end

    assign result.state   = next_state;
    assign result.is_text = text_flag;

endmodule

`default_nettype wire

// ----- rtl/core/html_token_state_machine_unit.sv -----
// top level: registered html character lexer with request and result channels
//
// The unit lexes one HTML byte per clock while results are taken. A request
// is captured in an input register; the state logic reads it together with
// the lexer state and, once the result register is empty or its result is
// taken, writes the new state and text flag into the result register, which
// presents them on the result channel. Requests are taken back to back at one
// per cycle while results are taken, and the input register keeps taking a
// byte while a finished result waits on the result channel; only when both
// registers are full and the result is not taken does ready drop. The lexer
// state starts in the text state after reset.
`default_nettype none

module html_token_state_machine_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    htsm_char_if.sink       chars,
    htsm_result_if.source   result
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [3:0]             out_state_reg;
    logic                   out_text_reg;
    htsm_pkg::htsm_state_t  lexer_state_reg;
    htsm_pkg::htsm_result_t step;
    logic                   advance;
    logic                   take;

    // handshake control
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;
    assign take = chars.valid && chars.ready;
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    // state logic
    htsm_step u_step (
        .state   (lexer_state_reg),
        .in_byte (in_byte_reg),
        .result  (step)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            lexer_state_reg <= htsm_pkg::ST_TEXT;
        end
        else
        begin
            in_valid_reg  <= take || (in_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            if (advance)
                lexer_state_reg <= step.state;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= chars.in_byte;
        if (advance)
        begin
            out_state_reg <= step.state;
            out_text_reg  <= step.is_text;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.new_state = out_state_reg;
    assign result.is_text   = out_text_reg;

    // the shown result always carries the current lexer state
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_state_reg == lexer_state_reg))
        else $error("result state differs from lexer state");

    // a text byte only ever leaves the lexer in text or entity state
    a_text_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_text_reg |->
            (out_state_reg == htsm_pkg::ST_TEXT) || (out_state_reg == htsm_pkg::ST_AMP))
        else $error("text flag with a markup state");

    // a held request is not dropped while the result side stalls
    a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result.ready |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending request lost during stall");

    // lexer state moves only when a request is processed
    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(lexer_state_reg))
        else $error("lexer state changed without a request");

endmodule

`default_nettype wire

// ----- tb/sv/html_token_state_machine_unit_checker.sv -----
// checker: predicts the lexer result of every accepted request and compares results
`timescale 1ns / 1ps

module html_token_state_machine_unit_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    htsm_char_if      chars,
    htsm_result_if    result,
    output int        error_count,
    output int        outstanding
);
    import htsm_pkg::*;

    typedef struct packed {
        logic [3:0] state;
        logic       is_text;
    } lex_result_t;

    logic [3:0]  lex_state;
    lex_result_t pending_lex_results[$];
    lex_result_t observed;
    lex_result_t predicted;
    int          errors_seen;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // inside a tag: '>' closes, '=' starts a value
    function automatic logic [3:0] tag_body_next(input logic [7:0] c);
        if (c == CH_GT)
            return ST_TEXT;
        if (c == CH_EQ)
            return ST_EQL;
        return ST_TAG;
    endfunction

    function automatic lex_result_t next_lex_result(input logic [3:0] cur,
                                                    input logic [7:0] c);
        lex_result_t r;
        r.state   = cur;
        r.is_text = 1'b0;
        case (cur)
            ST_TAG0:
                r.state = (c == CH_BANG) ? ST_CMNT1 : tag_body_next(c);
            ST_TAG:
                r.state = tag_body_next(c);
            ST_EQL:
            begin
                if (c == CH_DQUOTE)
                    r.state = ST_DQUOTE;
                else if (c == CH_SQUOTE)
                    r.state = ST_SQUOTE;
                else if (is_blank_char(c))
                    r.state = ST_EQL;
                else if (c == CH_GT)
                    r.state = ST_TEXT;
                else
                    r.state = ST_VALUE;
            end
            ST_SQUOTE:
                if (c == CH_SQUOTE)
                    r.state = ST_TAG;
            ST_DQUOTE:
                if (c == CH_DQUOTE)
                    r.state = ST_TAG;
            ST_VALUE:
            begin
                if (c == CH_GT)
                    r.state = ST_TEXT;
                else if (is_blank_char(c))
                    r.state = ST_TAG;
            end
            // entity name goes on over '#', '_' and ascii letters and digits
            ST_AMP:
                if (c == CH_SEMI ||
                    !(c == CH_HASH || c == CH_UNDER ||
                      (c >= 8'h30 && c <= 8'h39) ||
                      (c >= 8'h61 && c <= 8'h7A) ||
                      (c >= 8'h41 && c <= 8'h5A)))
                    r.state = ST_TEXT;
            ST_CMNT1:
                r.state = (c == CH_DASH) ? ST_CMNT2 : (c == CH_GT) ? ST_TEXT : ST_IRRTAG;
            ST_CMNT2:
                r.state = (c == CH_DASH) ? ST_CMNT : (c == CH_GT) ? ST_TEXT : ST_IRRTAG;
            ST_CMNT:
                if (c == CH_DASH)
                    r.state = ST_NCMNT1;
            ST_NCMNT1:
                r.state = (c == CH_DASH) ? ST_NCMNT2 : ST_CMNT;
            // closer stages after "--", with or without trailing blanks
            ST_NCMNT2, ST_NCMNT3:
            begin
                if (c == CH_GT)
                    r.state = ST_TEXT;
                else if (c == CH_DASH)
                    r.state = (cur == ST_NCMNT2) ? ST_NCMNT2 : ST_NCMNT1;
                else if (is_blank_char(c))
                    r.state = ST_NCMNT3;
                else
                    r.state = ST_CMNT;
            end
            ST_IRRTAG:
                if (c == CH_GT)
                    r.state = ST_TEXT;
            // text state, and the unused code
            default:
            begin
                if (c == CH_LT)
                    r.state = ST_TAG0;
                else
                begin
                    r.state   = (c == CH_AMP) ? ST_AMP : ST_TEXT;
                    r.is_text = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // compare results against the oldest prediction, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_state = ST_TEXT;
            pending_lex_results.delete();
            errors_seen = 0;
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                observed.state   = result.new_state;
                observed.is_text = result.is_text;
                if (pending_lex_results.size() == 0)
                begin
                    $display("%0t: unexpected result new_state %0d is_text %0b",
                             $time, observed.state, observed.is_text);
                    errors_seen++;
                end
                else
                begin
                    predicted = pending_lex_results.pop_front();
                    if (observed.state !== predicted.state)
                    begin
                        $display("%0t: new_state expected %0d actual %0d",
                                 $time, predicted.state, observed.state);
                        errors_seen++;
                    end
                    if (observed.is_text !== predicted.is_text)
                    begin
                        $display("%0t: is_text expected %0b actual %0b",
                                 $time, predicted.is_text, observed.is_text);
                        errors_seen++;
                    end
                end
            end
            if (chars.valid && chars.ready)
            begin
                predicted = next_lex_result(lex_state, chars.in_byte);
                lex_state = predicted.state;
                pending_lex_results.push_back(predicted);
            end
            error_count <= errors_seen;
            outstanding <= pending_lex_results.size();
        end
    end

endmodule

// ----- tb/sv/html_token_state_machine_unit_tb.sv -----
// testbench top: html byte stimulus, result stalls and the verdict
`timescale 1ns / 1ps

module html_token_state_machine_unit_tb;
    import htsm_pkg::*;

    localparam int DIRECTED_LEN = 28;
    localparam int TOTAL_ITEMS  = 1380;

    logic clk = 1'b0;
    logic rst_n;
    int   error_count;
    int   outstanding;
    int   sent_count = 0;
    int   send_mode  = 1;
    int   recv_mode  = 1;
    logic [7:0] char_stream[$];

    // entity, comment with closer blanks, tag with quoted and bare values, irregular tag
    logic [7:0] directed_chars [DIRECTED_LEN] = '{
        8'hFF, CH_AMP, CH_HASH, CH_SEMI,
        CH_LT, CH_BANG, CH_DASH, CH_DASH, CH_DASH, CH_DASH, CH_SPACE, CH_GT,
        CH_LT, 8'h61, CH_EQ, CH_DQUOTE, CH_DQUOTE, CH_EQ, CH_SQUOTE, CH_SQUOTE,
        CH_EQ, 8'h00, CH_TAB, CH_GT,
        CH_LT, CH_BANG, 8'h78, CH_GT
    };

    htsm_char_if   char_bus ();
    htsm_result_if result_bus ();

    html_token_state_machine_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_bus),
        .result (result_bus)
    );

    html_token_state_machine_unit_checker lex_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (char_bus),
        .result      (result_bus),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // idle cycles per item: none, uniformly random, or occasional bursts
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 8);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
        endcase
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'h30 + 8'(r);
        else if (r < 36)
            return 8'h61 + 8'(r - 10);
        return 8'h41 + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 6);
        return (r < 5) ? CH_TAB + 8'(r) : CH_SPACE;
    endfunction

    // queue one piece of markup: text, entity, tag, comment, irregular tag or noise
    task automatic add_fragment();
        int n;
        int attrs;
        int k;
        logic [7:0] c;
        case ($urandom_range(0, 13))
            0, 1, 2, 3:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    c = 8'($urandom_range(0, 255));
                    char_stream.push_back((c == CH_LT) ? CH_SPACE : c);
                end
            end
            4, 5:
            begin
                char_stream.push_back(CH_AMP);
                if ($urandom_range(0, 1) == 0)
                    char_stream.push_back(CH_HASH);
                n = $urandom_range(0, 4);
                repeat (n)
                    char_stream.push_back(($urandom_range(0, 7) == 0) ? CH_UNDER
                                                                     : rand_name_char());
                if ($urandom_range(0, 2) == 0)
                    char_stream.push_back(8'($urandom_range(0, 255)));
                else
                    char_stream.push_back(CH_SEMI);
            end
            6, 7, 8, 9:
            begin
                char_stream.push_back(CH_LT);
                n = $urandom_range(1, 4);
                repeat (n)
                    char_stream.push_back(rand_name_char());
                attrs = $urandom_range(0, 3);
                repeat (attrs)
                begin
                    n = $urandom_range(1, 2);
                    repeat (n)
                        char_stream.push_back(rand_blank());
                    n = $urandom_range(1, 3);
                    repeat (n)
                        char_stream.push_back(rand_name_char());
                    if ($urandom_range(0, 3) != 0)
                    begin
                        char_stream.push_back(CH_EQ);
                        if ($urandom_range(0, 3) == 0)
                            char_stream.push_back(rand_blank());
                        k = $urandom_range(0, 3);
                        // double quoted, single quoted, bare or empty value
                        if (k < 2)
                        begin
                            c = (k == 0) ? CH_DQUOTE : CH_SQUOTE;
                            char_stream.push_back(c);
                            n = $urandom_range(0, 4);
                            repeat (n)
                            begin
                                logic [7:0] v;
                                v = 8'($urandom_range(0, 255));
                                char_stream.push_back((v == c) ? 8'h78 : v);
                            end
                            char_stream.push_back(c);
                        end
                        else if (k == 2)
                        begin
                            n = $urandom_range(1, 3);
                            repeat (n)
                                char_stream.push_back(rand_name_char());
                        end
                    end
                end
                if ($urandom_range(0, 2) == 0)
                    char_stream.push_back(rand_blank());
                char_stream.push_back(CH_GT);
            end
            10, 11:
            begin
                char_stream.push_back(CH_LT);
                char_stream.push_back(CH_BANG);
                char_stream.push_back(CH_DASH);
                char_stream.push_back(CH_DASH);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    k = $urandom_range(0, 4);
                    if (k < 2)
                        char_stream.push_back(CH_DASH);
                    else if (k == 2)
                        char_stream.push_back(rand_blank());
                    else if (k == 3)
                        char_stream.push_back(CH_GT);
                    else
                        char_stream.push_back(8'($urandom_range(0, 255)));
                end
                // closer, sometimes with blanks before '>'
                char_stream.push_back(CH_DASH);
                char_stream.push_back(CH_DASH);
                n = $urandom_range(0, 2);
                repeat (n)
                    char_stream.push_back(rand_blank());
                char_stream.push_back(CH_GT);
            end
            12:
            begin
                char_stream.push_back(CH_LT);
                char_stream.push_back(CH_BANG);
                k = $urandom_range(0, 2);
                if (k == 0)
                    char_stream.push_back(CH_GT);
                else
                begin
                    if (k == 1)
                        char_stream.push_back(CH_DASH);
                    c = 8'($urandom_range(0, 255));
                    char_stream.push_back((c == CH_DASH) ? 8'h78 : c);
                    n = $urandom_range(0, 3);
                    repeat (n)
                    begin
                        c = 8'($urandom_range(0, 255));
                        char_stream.push_back((c == CH_GT) ? 8'h78 : c);
                    end
                    char_stream.push_back(CH_GT);
                end
            end
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    char_stream.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // one request, after a random gap with junk on the byte lines
    task automatic send_char(input logic [7:0] b);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            char_bus.valid   <= 1'b0;
            char_bus.in_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.in_byte <= b;
        do @(posedge clk); while (!char_bus.ready);
        sent_count++;
    endtask

    // reset, stimulus and verdict
    initial
    begin
        rst_n             <= 1'b0;
        char_bus.valid    <= 1'b0;
        char_bus.in_byte  <= 8'h00;
        result_bus.ready  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_chars[i])
            char_stream.push_back(directed_chars[i]);
        while (char_stream.size() > 0 || sent_count < TOTAL_ITEMS)
        begin
            if (char_stream.size() == 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_mode = $urandom_range(0, 2);
                add_fragment();
            end
            send_char(char_stream.pop_front());
        end
        char_bus.valid <= 1'b0;

        // drain, then stay idle to catch stray results
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("html_token_state_machine_unit_tb: PASS");
        else
            $display("html_token_state_machine_unit_tb: FAIL");
        $finish;
    end

    // result side stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                recv_mode = $urandom_range(0, 2);
            stall = draw_wait(recv_mode);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("html_token_state_machine_unit_tb: FAIL");
        $finish;
    end

endmodule
